/* hdl/brir_pkg.sv */
// Package for the bilinear RGB image resizer.
// Holds field widths, fixed-point constants, register indexes and item kinds.
// No dependencies.
package brir_pkg;

    localparam int COORD_W    = 9;
    localparam int CH_W       = 8;
    localparam int SIZE_REG_W = 10;
    localparam int SCALE_W    = 26;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    // Signed Q.16 weight, range -0.5 .. 1.5.
    localparam int WGT_W      = 18;
    localparam int ONE_Q16    = 65536;

    localparam logic [SIZE_REG_W-1:0] SRC_WIDTH_RST  = 10'd224;
    localparam logic [SIZE_REG_W-1:0] SRC_HEIGHT_RST = 10'd224;
    localparam logic [SCALE_W-1:0]    X_SCALE_RST    = 26'd65536;
    localparam logic [SCALE_W-1:0]    Y_SCALE_RST    = 26'd65536;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        REG_SRC_WIDTH,
        REG_SRC_HEIGHT,
        REG_X_SCALE,
        REG_Y_SCALE
    } t_reg_idx;

endpackage

/* hdl/bilinear_rgb_image_resize_top.sv */
// Top level of the bilinear RGB image resizer: frame memory and bilinear sampler.
// Depends on brir_pkg.
// Contains the APB register file, the coordinate mapping pipeline and the blend pipeline.

// A load beat writes one RGB pixel into the frame memory, if its column and row are in range,
// and takes one access of the memory port; a query beat reads its four neighbor pixels through
// the same single port, one per cycle, so a new query is issued only after the last read of the
// one before, and loads go at one per cycle while no query holds the port. The frame memory is
// not cleared after reset: a query must only touch pixels that were loaded before it. The
// registers must be written only while no beat is in flight; the block does not enforce it.
module bilinear_rgb_image_resize_top #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_kind,
    input  logic [brir_pkg::COORD_W-1:0]   i_col,
    input  logic [brir_pkg::COORD_W-1:0]   i_row,
    input  logic [brir_pkg::CH_W-1:0]      i_in_red,
    input  logic [brir_pkg::CH_W-1:0]      i_in_green,
    input  logic [brir_pkg::CH_W-1:0]      i_in_blue,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [brir_pkg::CH_W-1:0]      o_out_red,
    output logic [brir_pkg::CH_W-1:0]      o_out_green,
    output logic [brir_pkg::CH_W-1:0]      o_out_blue,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [brir_pkg::PADDR_W-1:0]   paddr,
    input  logic [brir_pkg::PDATA_W-1:0]   pwdata,
    output logic [brir_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import brir_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int SWW   = $clog2(MAX_WIDTH + 1);
    localparam int SHW   = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int PIX_W = 3 * CH_W;
    localparam int TW    = COORD_W + 1 + SCALE_W;
    localparam int QW    = TW - 16;
    localparam int PW    = WGT_W + CH_W + 1;
    localparam int VW    = WGT_W + PW;
    localparam int SUMW  = VW + 1;

    localparam logic [1:0] CREDITS = 2'd3;

    typedef enum logic [1:0] {
        NB_TL,
        NB_TR,
        NB_BL,
        NB_BR
    } t_nbr;

    // Configuration registers.
    logic [SIZE_REG_W-1:0] r_src_width;
    logic [SIZE_REG_W-1:0] r_src_height;
    logic [SCALE_W-1:0]    r_x_scale;
    logic [SCALE_W-1:0]    r_y_scale;
    logic                  cfg_we;
    t_reg_idx              cfg_idx;

    logic [SWW-1:0] eff_w;
    logic [SHW-1:0] eff_h;

    // Pipeline control.
    logic       r_s0_v, r_s1_v, r_s2_v, r_sq_v, r_rd_v, r_g_v, r_v_v, r_o_v;
    logic [1:0] r_cnt;
    logic       in_acc, s0_adv, s1_adv, s2_adv, issue, sq_done, g_load, g_adv, v_adv, o_ready;
    logic       cnt_inc, cnt_dec;

    // Stage payloads.
    logic               r_s0_kind, r_s1_kind, r_s2_kind, r_sq_kind;
    logic [COORD_W-1:0] r_s0_col, r_s1_col, r_s2_col, r_sq_col;
    logic [COORD_W-1:0] r_s0_row, r_s1_row, r_s2_row, r_sq_row;
    logic [PIX_W-1:0]   r_s0_rgb, r_s1_rgb, r_s2_rgb, r_sq_rgb;
    logic [TW-1:0]      r_s1_tx, r_s1_ty;

    logic [XW-1:0]           r_s2_x0, r_s2_x1, r_sq_x0, r_sq_x1;
    logic [YW-1:0]           r_s2_y0, r_s2_y1, r_sq_y0, r_sq_y1;
    logic signed [WGT_W-1:0] r_s2_wx0, r_s2_wx1, r_s2_wy0, r_s2_wy1;
    logic signed [WGT_W-1:0] r_sq_wx0, r_sq_wx1, r_sq_wy0, r_sq_wy1;
    t_nbr                    r_sq_phase;

    // Axis mapping.
    logic [TW:0]             sx_sum, sy_sum;
    logic [QW-1:0]           qx, qy, ax_full, ay_full, wlast, hlast;
    logic [15:0]             fx, fy;
    logic                    x_edge, y_edge;
    logic [XW-1:0]           ax, bx;
    logic [YW-1:0]           ay, by;
    logic signed [WGT_W-1:0] wx1, wx0, wy1, wy0;

    // Frame memory.
    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] r_mem_q;
    logic [AW-1:0]    mem_addr;
    logic             mem_we, mem_re, load_in_range;
    logic [XW-1:0]    sel_x;
    logic [YW-1:0]    sel_y;

    // Blend.
    t_nbr                    r_rd_phase;
    logic signed [WGT_W-1:0] r_rd_wx, r_rd_wy0, r_rd_wy1;
    logic signed [PW-1:0]    prod  [3];
    logic signed [PW-1:0]    r_top [3];
    logic signed [PW-1:0]    r_bot [3];
    logic signed [PW-1:0]    r_g_top [3];
    logic signed [PW-1:0]    r_g_bot [3];
    logic signed [WGT_W-1:0] r_g_wy0, r_g_wy1;
    logic signed [VW-1:0]    r_v_a [3];
    logic signed [VW-1:0]    r_v_b [3];
    logic signed [SUMW-1:0]  vsum  [3];
    logic [SUMW-1:0]         vrnd  [3];
    logic [CH_W-1:0]         pix_out [3];
    logic [CH_W-1:0]         r_o_pix [3];

    // Register file.
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= SRC_WIDTH_RST;
            r_src_height <= SRC_HEIGHT_RST;
            r_x_scale    <= X_SCALE_RST;
            r_y_scale    <= Y_SCALE_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_SRC_WIDTH:  r_src_width  <= pwdata[SIZE_REG_W-1:0];
                REG_SRC_HEIGHT: r_src_height <= pwdata[SIZE_REG_W-1:0];
                REG_X_SCALE:    r_x_scale    <= pwdata[SCALE_W-1:0];
                REG_Y_SCALE:    r_y_scale    <= pwdata[SCALE_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_SRC_WIDTH:  prdata = PDATA_W'(r_src_width);
            REG_SRC_HEIGHT: prdata = PDATA_W'(r_src_height);
            REG_X_SCALE:    prdata = PDATA_W'(r_x_scale);
            REG_Y_SCALE:    prdata = PDATA_W'(r_y_scale);
        endcase
    end

    always_comb begin
        if (r_src_width == '0) begin
            eff_w = SWW'(1);
        end else if (32'(r_src_width) > MAX_WIDTH) begin
            eff_w = SWW'(MAX_WIDTH);
        end else begin
            eff_w = SWW'(r_src_width);
        end
        if (r_src_height == '0) begin
            eff_h = SHW'(1);
        end else if (32'(r_src_height) > MAX_HEIGHT) begin
            eff_h = SHW'(MAX_HEIGHT);
        end else begin
            eff_h = SHW'(r_src_height);
        end
    end

    // Handshake chain.
    always_comb begin
        o_ready    = !r_o_v || !i_out_stall;
        v_adv      = r_v_v && o_ready;
        g_adv      = r_g_v && (!r_v_v || v_adv);
        g_load     = r_rd_v && (r_rd_phase == NB_BR);
        issue      = r_sq_v && (r_sq_kind == KIND_LOAD || r_sq_phase != NB_TL
                                || r_cnt < CREDITS);
        sq_done    = issue && (r_sq_kind == KIND_LOAD || r_sq_phase == NB_BR);
        s2_adv     = r_s2_v && (!r_sq_v || sq_done);
        s1_adv     = r_s1_v && (!r_s2_v || s2_adv);
        s0_adv     = r_s0_v && (!r_s1_v || s1_adv);
        o_in_stall = r_s0_v && !s0_adv;
        in_acc     = i_in_valid && !o_in_stall;
        cnt_inc    = issue && r_sq_kind == KIND_QUERY && r_sq_phase == NB_TL;
        cnt_dec    = r_o_v && !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v     <= 1'b0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_sq_v     <= 1'b0;
            r_sq_phase <= NB_TL;
            r_rd_v     <= 1'b0;
            r_g_v      <= 1'b0;
            r_v_v      <= 1'b0;
            r_o_v      <= 1'b0;
            r_cnt      <= '0;
        end else begin
            if (in_acc) begin
                r_s0_v <= 1'b1;
            end else if (s0_adv) begin
                r_s0_v <= 1'b0;
            end
            if (s0_adv) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_v <= 1'b1;
            end else if (s2_adv) begin
                r_s2_v <= 1'b0;
            end
            if (s2_adv) begin
                r_sq_v     <= 1'b1;
                r_sq_phase <= NB_TL;
            end else if (sq_done) begin
                r_sq_v <= 1'b0;
            end else if (issue) begin
                r_sq_phase <= t_nbr'(r_sq_phase + 2'd1);
            end
            r_rd_v <= mem_re;
            if (g_load) begin
                r_g_v <= 1'b1;
            end else if (g_adv) begin
                r_g_v <= 1'b0;
            end
            if (g_adv) begin
                r_v_v <= 1'b1;
            end else if (v_adv) begin
                r_v_v <= 1'b0;
            end
            if (v_adv) begin
                r_o_v <= 1'b1;
            end else if (cnt_dec) begin
                r_o_v <= 1'b0;
            end
            if (cnt_inc && !cnt_dec) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!cnt_inc && cnt_dec) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Axis mapping: s + 1 = ((2d + 1) * scale + 1) / 2 in Q.16, then floor and clamp.
    always_comb begin
        sx_sum  = {1'b0, r_s1_tx} + (TW+1)'(ONE_Q16);
        sy_sum  = {1'b0, r_s1_ty} + (TW+1)'(ONE_Q16);
        qx      = sx_sum[TW:17];
        qy      = sy_sum[TW:17];
        fx      = sx_sum[16:1];
        fy      = sy_sum[16:1];
        wlast   = QW'(eff_w) - QW'(1);
        hlast   = QW'(eff_h) - QW'(1);

        if (qx > QW'(eff_w)) begin
            ax_full = wlast;
        end else if (qx == '0) begin
            ax_full = '0;
        end else begin
            ax_full = qx - QW'(1);
        end
        if (qy > QW'(eff_h)) begin
            ay_full = hlast;
        end else if (qy == '0) begin
            ay_full = '0;
        end else begin
            ay_full = qy - QW'(1);
        end

        x_edge = (ax_full == wlast);
        y_edge = (ay_full == hlast);
        ax     = ax_full[XW-1:0];
        ay     = ay_full[YW-1:0];
        bx     = x_edge ? ax : ax + XW'(1);
        by     = y_edge ? ay : ay + YW'(1);

        if (x_edge) begin
            wx1 = '0;
        end else if (qx == '0) begin
            wx1 = {2'b11, fx};
        end else begin
            wx1 = {2'b00, fx};
        end
        if (y_edge) begin
            wy1 = '0;
        end else if (qy == '0) begin
            wy1 = {2'b11, fy};
        end else begin
            wy1 = {2'b00, fy};
        end
        wx0 = WGT_W'(ONE_Q16) - wx1;
        wy0 = WGT_W'(ONE_Q16) - wy1;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s0_kind <= i_kind;
            r_s0_col  <= i_col;
            r_s0_row  <= i_row;
            r_s0_rgb  <= {i_in_red, i_in_green, i_in_blue};
        end
        if (s0_adv) begin
            r_s1_kind <= r_s0_kind;
            r_s1_col  <= r_s0_col;
            r_s1_row  <= r_s0_row;
            r_s1_rgb  <= r_s0_rgb;
            r_s1_tx   <= TW'({r_s0_col, 1'b1}) * TW'(r_x_scale);
            r_s1_ty   <= TW'({r_s0_row, 1'b1}) * TW'(r_y_scale);
        end
        if (s1_adv) begin
            r_s2_kind <= r_s1_kind;
            r_s2_col  <= r_s1_col;
            r_s2_row  <= r_s1_row;
            r_s2_rgb  <= r_s1_rgb;
            r_s2_x0   <= ax;
            r_s2_x1   <= bx;
            r_s2_y0   <= ay;
            r_s2_y1   <= by;
            r_s2_wx0  <= wx0;
            r_s2_wx1  <= wx1;
            r_s2_wy0  <= wy0;
            r_s2_wy1  <= wy1;
        end
        if (s2_adv) begin
            r_sq_kind <= r_s2_kind;
            r_sq_col  <= r_s2_col;
            r_sq_row  <= r_s2_row;
            r_sq_rgb  <= r_s2_rgb;
            r_sq_x0   <= r_s2_x0;
            r_sq_x1   <= r_s2_x1;
            r_sq_y0   <= r_s2_y0;
            r_sq_y1   <= r_s2_y1;
            r_sq_wx0  <= r_s2_wx0;
            r_sq_wx1  <= r_s2_wx1;
            r_sq_wy0  <= r_s2_wy0;
            r_sq_wy1  <= r_s2_wy1;
        end
    end

    // Memory port sequencer: one access per cycle, except while a query waits for a credit.
    always_comb begin
        load_in_range = (32'(r_sq_col) < MAX_WIDTH) && (32'(r_sq_row) < MAX_HEIGHT);
        unique case (r_sq_phase)
            NB_TL: begin
                sel_x = r_sq_x0;
                sel_y = r_sq_y0;
            end
            NB_TR: begin
                sel_x = r_sq_x1;
                sel_y = r_sq_y0;
            end
            NB_BL: begin
                sel_x = r_sq_x0;
                sel_y = r_sq_y1;
            end
            NB_BR: begin
                sel_x = r_sq_x1;
                sel_y = r_sq_y1;
            end
        endcase
        if (r_sq_kind == KIND_LOAD) begin
            sel_x = XW'(r_sq_col);
            sel_y = YW'(r_sq_row);
        end
        mem_addr = AW'(sel_y) * AW'(MAX_WIDTH) + AW'(sel_x);
        mem_we   = issue && r_sq_kind == KIND_LOAD && load_in_range;
        mem_re   = issue && r_sq_kind == KIND_QUERY;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= r_sq_rgb;
        end
        if (mem_re) begin
            r_mem_q <= mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_phase <= r_sq_phase;
            r_rd_wx    <= (r_sq_phase == NB_TL || r_sq_phase == NB_BL) ? r_sq_wx0 : r_sq_wx1;
            r_rd_wy0   <= r_sq_wy0;
            r_rd_wy1   <= r_sq_wy1;
        end
    end

    // Horizontal blend as the neighbor pixels arrive, vertical blend afterward.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod[c] = PW'(r_rd_wx) * PW'($signed({1'b0, r_mem_q[(2-c)*CH_W +: CH_W]}));
            vsum[c] = SUMW'(r_v_a[c]) + SUMW'(r_v_b[c]);
            vrnd[c] = SUMW'(vsum[c]) + SUMW'(64'h8000_0000);
            if (vsum[c] < 0) begin
                pix_out[c] = '0;
            end else if (vrnd[c][SUMW-1:32] > (SUMW-32)'(255)) begin
                pix_out[c] = 8'hFF;
            end else begin
                pix_out[c] = vrnd[c][39:32];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (r_rd_v) begin
                unique case (r_rd_phase)
                    NB_TL: r_top[c] <= prod[c];
                    NB_TR: r_top[c] <= r_top[c] + prod[c];
                    NB_BL: r_bot[c] <= prod[c];
                    NB_BR: begin
                        r_g_top[c] <= r_top[c];
                        r_g_bot[c] <= r_bot[c] + prod[c];
                    end
                endcase
            end
            if (g_adv) begin
                r_v_a[c] <= VW'(r_g_wy0) * VW'(r_g_top[c]);
                r_v_b[c] <= VW'(r_g_wy1) * VW'(r_g_bot[c]);
            end
            if (v_adv) begin
                r_o_pix[c] <= pix_out[c];
            end
        end
        if (g_load) begin
            r_g_wy0 <= r_rd_wy0;
            r_g_wy1 <= r_rd_wy1;
        end
    end

    assign o_out_valid = r_o_v;
    assign o_out_red   = r_o_pix[0];
    assign o_out_green = r_o_pix[1];
    assign o_out_blue  = r_o_pix[2];

endmodule

/* bench/testbench.sv */
// Self-checking testbench for bilinear_rgb_image_resize_top: a table of directed beats, then
// random register settings with frame loads and bilinear queries checked against a predictor.
// Depends on brir_pkg and the top level of the resizer.
module testbench;

    import brir_pkg::*;

    localparam int MAX_WIDTH    = 512;
    localparam int MAX_HEIGHT   = 512;
    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 24;
    localparam int IDLE_LIMIT   = 2000;
    localparam int MAX_IDLE     = 12;
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_BEATS  = 32;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef enum { ROW_LOAD, ROW_QUERY, ROW_CFG } t_row_op;

    typedef struct {
        t_row_op          op;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        t_rgb             pix;
        bit               hand_checked;
        t_reg_idx         sel;
        logic [31:0]      value;
    } t_plan_row;

    t_plan_row directed_plan [$] = '{
        '{ROW_LOAD,  9'd0,   9'd0,   24'hFF0080, 1'b0, REG_SRC_WIDTH,  32'd0},
        '{ROW_LOAD,  9'd1,   9'd0,   24'h00FF80, 1'b0, REG_SRC_WIDTH,  32'd0},
        '{ROW_LOAD,  9'd0,   9'd1,   24'h00FF80, 1'b0, REG_SRC_WIDTH,  32'd0},
        '{ROW_LOAD,  9'd1,   9'd1,   24'h00FF80, 1'b0, REG_SRC_WIDTH,  32'd0},
        '{ROW_QUERY, 9'd0,   9'd0,   24'hFF0080, 1'b1, REG_SRC_WIDTH,  32'd0},
        '{ROW_LOAD,  9'd223, 9'd223, 24'h123456, 1'b0, REG_SRC_WIDTH,  32'd0},
        '{ROW_QUERY, 9'd223, 9'd223, 24'h123456, 1'b1, REG_SRC_WIDTH,  32'd0},
        '{ROW_QUERY, 9'd300, 9'd400, 24'h123456, 1'b1, REG_SRC_WIDTH,  32'd0},
        '{ROW_LOAD,  9'd511, 9'd511, 24'hFFFFFF, 1'b0, REG_SRC_WIDTH,  32'd0},
        '{ROW_CFG,   9'd0,   9'd0,   24'h000000, 1'b0, REG_X_SCALE,    32'd0},
        '{ROW_CFG,   9'd0,   9'd0,   24'h000000, 1'b0, REG_Y_SCALE,    32'd0},
        '{ROW_QUERY, 9'd511, 9'd511, 24'hFF0080, 1'b1, REG_SRC_WIDTH,  32'd0},
        '{ROW_QUERY, 9'd0,   9'd0,   24'hFF0080, 1'b1, REG_SRC_WIDTH,  32'd0},
        '{ROW_CFG,   9'd0,   9'd0,   24'h000000, 1'b0, REG_X_SCALE,    32'd32768},
        '{ROW_QUERY, 9'd0,   9'd0,   24'h000000, 1'b0, REG_SRC_WIDTH,  32'd0},
        '{ROW_QUERY, 9'd0,   9'd400, 24'h000000, 1'b0, REG_SRC_WIDTH,  32'd0},
        '{ROW_CFG,   9'd0,   9'd0,   24'h000000, 1'b0, REG_SRC_WIDTH,  32'd0},
        '{ROW_QUERY, 9'd5,   9'd5,   24'h000000, 1'b0, REG_SRC_WIDTH,  32'd0},
        '{ROW_CFG,   9'd0,   9'd0,   24'h000000, 1'b0, REG_SRC_WIDTH,  32'd1023},
        '{ROW_CFG,   9'd0,   9'd0,   24'h000000, 1'b0, REG_SRC_HEIGHT, 32'd700},
        '{ROW_CFG,   9'd0,   9'd0,   24'h000000, 1'b0, REG_X_SCALE,    32'd65536},
        '{ROW_CFG,   9'd0,   9'd0,   24'h000000, 1'b0, REG_Y_SCALE,    32'd65536},
        '{ROW_QUERY, 9'd511, 9'd511, 24'hFFFFFF, 1'b1, REG_SRC_WIDTH,  32'd0},
        '{ROW_CFG,   9'd0,   9'd0,   24'h000000, 1'b0, REG_X_SCALE,    32'd33554432},
        '{ROW_CFG,   9'd0,   9'd0,   24'h000000, 1'b0, REG_Y_SCALE,    32'd67108863},
        '{ROW_QUERY, 9'd1,   9'd1,   24'hFFFFFF, 1'b1, REG_SRC_WIDTH,  32'd0}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_kind;
    logic [COORD_W-1:0]  i_col;
    logic [COORD_W-1:0]  i_row;
    logic [CH_W-1:0]     i_in_red;
    logic [CH_W-1:0]     i_in_green;
    logic [CH_W-1:0]     i_in_blue;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [CH_W-1:0]     o_out_red;
    logic [CH_W-1:0]     o_out_green;
    logic [CH_W-1:0]     o_out_blue;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    t_rgb                frame_mem [0:MAX_HEIGHT-1][0:MAX_WIDTH-1];
    bit                  loaded_map [0:MAX_HEIGHT-1][0:MAX_WIDTH-1];
    logic [SIZE_REG_W-1:0] cfg_width  = SRC_WIDTH_RST;
    logic [SIZE_REG_W-1:0] cfg_height = SRC_HEIGHT_RST;
    logic [SCALE_W-1:0]  cfg_x_scale  = X_SCALE_RST;
    logic [SCALE_W-1:0]  cfg_y_scale  = Y_SCALE_RST;
    t_rgb                expected_pixels [$];
    int                  mismatches = 0;
    bit                  in_quiet   = 1'b0;
    bit                  out_quiet  = 1'b0;

    bilinear_rgb_image_resize_top #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_in_red    (i_in_red),
        .i_in_green  (i_in_green),
        .i_in_blue   (i_in_blue),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic int unsigned fit_size(input logic [SIZE_REG_W-1:0] v,
                                             input int unsigned limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    // Half-pixel-center mapping of one axis to two clamped neighbors and the far weight.
    function automatic void sample_axis(input logic [COORD_W-1:0] d,
                                        input logic [SCALE_W-1:0] scale,
                                        input int unsigned size,
                                        output int unsigned i0, output int unsigned i1,
                                        output longint w1);
        longint unsigned prod;
        longint pos;
        longint base;
        prod = longint'(2 * longint'(d) + 1) * longint'(scale);
        pos  = longint'((prod + longint'(ONE_Q16)) >> 1) - ONE_Q16;
        base = ((pos + ONE_Q16) >>> 16) - 1;
        if (base < 0) base = 0;
        if (base > longint'(size) - 1) base = longint'(size) - 1;
        i0 = int'(base);
        i1 = (i0 + 1 > size - 1) ? size - 1 : i0 + 1;
        w1 = (i0 == i1) ? 0 : pos - longint'(i0) * ONE_Q16;
    endfunction

    function automatic t_rgb predict_pixel(input logic [COORD_W-1:0] col,
                                           input logic [COORD_W-1:0] row);
        int unsigned x0, x1, y0, y1;
        longint wx0, wx1, wy0, wy1, top, bot, acc, level;
        logic [23:0] p00, p01, p10, p11, blend;
        sample_axis(col, cfg_x_scale, fit_size(cfg_width, MAX_WIDTH), x0, x1, wx1);
        sample_axis(row, cfg_y_scale, fit_size(cfg_height, MAX_HEIGHT), y0, y1, wy1);
        wx0 = ONE_Q16 - wx1;
        wy0 = ONE_Q16 - wy1;
        p00 = frame_mem[y0][x0];
        p01 = frame_mem[y0][x1];
        p10 = frame_mem[y1][x0];
        p11 = frame_mem[y1][x1];
        for (int c = 0; c < 3; c++) begin
            top = wx0 * longint'(p00[23-8*c -: 8]) + wx1 * longint'(p01[23-8*c -: 8]);
            bot = wx0 * longint'(p10[23-8*c -: 8]) + wx1 * longint'(p11[23-8*c -: 8]);
            acc = wy0 * top + wy1 * bot;
            if (acc < 0) begin
                level = 0;
            end else begin
                level = (acc + 64'sh80000000) >>> 32;
            end
            if (level > 255) level = 255;
            blend[23-8*c -: 8] = level[7:0];
        end
        return blend;
    endfunction

    function automatic void pick_scale(input int unsigned size,
                                       output logic [SCALE_W-1:0] scale,
                                       output int unsigned span);
        int unsigned dst;
        case ($urandom_range(0, 7))
            0: begin
                scale = '0;
                span = 511;
            end
            1: begin
                scale = '1;
                span = 3;
            end
            2: begin
                scale = SCALE_W'($urandom());
                span = 511;
            end
            3: begin
                scale = SCALE_W'(ONE_Q16);
                span = size + 2;
            end
            default: begin
                dst = $urandom_range(1, 2 * size + 4);
                scale = SCALE_W'(((size << 16) / dst) + $urandom_range(0, 63));
                span = dst + 1;
            end
        endcase
        if (span > 511) span = 511;
    endfunction

    task automatic send_beat(input logic kind, input logic [COORD_W-1:0] col,
                             input logic [COORD_W-1:0] row, input t_rgb pix,
                             input bit hand_checked);
        int unsigned gap;
        logic [23:0] junk;
        gap = in_quiet ? 0 : $urandom_range(0, MAX_IDLE);
        junk = 24'($urandom());
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_col <= col;
        i_row <= row;
        if (kind == KIND_LOAD) begin
            {i_in_red, i_in_green, i_in_blue} <= pix;
        end else begin
            {i_in_red, i_in_green, i_in_blue} <= junk;
        end
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        if (kind == KIND_LOAD) begin
            frame_mem[row][col] = pix;
            loaded_map[row][col] = 1'b1;
        end else begin
            expected_pixels.push_back(hand_checked ? pix : predict_pixel(col, row));
        end
        @(negedge i_clk);
    endtask

    // Leaves the block idle: no beat offered, every result delivered, pipeline empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_access(input bit is_write, input t_reg_idx sel,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= {sel, 2'b00};
        pwdata <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_register(input t_reg_idx sel, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] readback;
        logic [PDATA_W-1:0] held;
        apb_access(1'b1, sel, value, readback);
        case (sel)
            REG_SRC_WIDTH:  cfg_width   = value[SIZE_REG_W-1:0];
            REG_SRC_HEIGHT: cfg_height  = value[SIZE_REG_W-1:0];
            REG_X_SCALE:    cfg_x_scale = value[SCALE_W-1:0];
            REG_Y_SCALE:    cfg_y_scale = value[SCALE_W-1:0];
            default: ;
        endcase
        held = (sel == REG_SRC_WIDTH || sel == REG_SRC_HEIGHT) ?
               PDATA_W'(value[SIZE_REG_W-1:0]) : PDATA_W'(value[SCALE_W-1:0]);
        apb_access(1'b0, sel, '0, readback);
        if (readback !== held) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("register %s readback: expected %0d, got %0d",
                         sel.name(), held, readback);
            end
        end
    endtask

    initial begin : result_check
        int unsigned hold;
        t_rgb got;
        t_rgb want;
        i_out_stall = 1'b0;
        forever begin
            hold = out_quiet ? 0 : $urandom_range(0, MAX_IDLE);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got = {o_out_red, o_out_green, o_out_blue};
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result beat r=%0d g=%0d b=%0d",
                             got.red, got.green, got.blue);
                end
            end else begin
                want = expected_pixels.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                 want.red, want.green, want.blue,
                                 got.red, got.green, got.blue);
                    end
                end
            end
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        int idle_run;
        idle_run = 0;
        while (idle_run < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && i_out_stall === 1'b0) || psel === 1'b1) begin
                idle_run = 0;
            end else begin
                idle_run++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int unsigned w, h, span_x, span_y, choice;
        logic [SIZE_REG_W-1:0] wv, hv;
        logic [SCALE_W-1:0] xs, ys;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_kind = KIND_LOAD;
        i_col = '0;
        i_row = '0;
        i_in_red = '0;
        i_in_green = '0;
        i_in_blue = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_plan[n]) begin
            case (directed_plan[n].op)
                ROW_CFG: begin
                    settle();
                    program_register(directed_plan[n].sel, directed_plan[n].value);
                end
                ROW_LOAD: begin
                    send_beat(KIND_LOAD, directed_plan[n].col, directed_plan[n].row,
                              directed_plan[n].pix, 1'b0);
                end
                default: begin
                    send_beat(KIND_QUERY, directed_plan[n].col, directed_plan[n].row,
                              directed_plan[n].pix, directed_plan[n].hand_checked);
                end
            endcase
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    wv = 10'd0;
                    hv = 10'd3;
                end
                1: begin
                    wv = 10'd5;
                    hv = 10'd0;
                end
                2: begin
                    wv = 10'd1;
                    hv = 10'd1;
                end
                default: begin
                    wv = ($urandom_range(0, 7) == 0) ? 10'd0 : 10'($urandom_range(1, 12));
                    hv = 10'($urandom_range(1, 12));
                end
            endcase
            w = fit_size(wv, MAX_WIDTH);
            h = fit_size(hv, MAX_HEIGHT);
            pick_scale(w, xs, span_x);
            pick_scale(h, ys, span_y);
            settle();
            program_register(REG_SRC_WIDTH, {22'($urandom()), wv});
            program_register(REG_SRC_HEIGHT, {22'($urandom()), hv});
            program_register(REG_X_SCALE, {6'($urandom()), xs});
            program_register(REG_Y_SCALE, {6'($urandom()), ys});
            in_quiet = ($urandom_range(0, 3) == 0);
            out_quiet = ($urandom_range(0, 3) == 0);

            // Every pixel a query can reach must be loaded before the first query.
            for (int y = 0; y < h; y++) begin
                for (int x = 0; x < w; x++) begin
                    if (!loaded_map[y][x]) begin
                        send_beat(KIND_LOAD, COORD_W'(x), COORD_W'(y), t_rgb'($urandom()), 1'b0);
                    end
                end
            end

            for (int k = 0; k < PHASE_BEATS; k++) begin
                choice = $urandom_range(0, 19);
                if (choice < 15) begin
                    send_beat(KIND_QUERY,
                              ($urandom_range(0, 5) == 0) ? COORD_W'($urandom()) :
                                  COORD_W'($urandom_range(0, span_x)),
                              ($urandom_range(0, 5) == 0) ? COORD_W'($urandom()) :
                                  COORD_W'($urandom_range(0, span_y)),
                              t_rgb'(0), 1'b0);
                end else if (choice < 18) begin
                    send_beat(KIND_LOAD, COORD_W'($urandom_range(0, w - 1)),
                              COORD_W'($urandom_range(0, h - 1)), t_rgb'($urandom()), 1'b0);
                end else begin
                    send_beat(KIND_LOAD, COORD_W'($urandom()), COORD_W'($urandom()),
                              t_rgb'($urandom()), 1'b0);
                end
            end
        end

        settle();
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/brir_pkg.sv
hdl/bilinear_rgb_image_resize_top.sv
bench/testbench.sv
